[sv/hcu_pkg.sv]
// Shared types and constants for the hex cell union perimeter block.
// Used by hcu_seq and hex_cell_union_perimeter; no dependencies.
package hcu_pkg;

  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_HEIGHT_DEF = 64;
  localparam int EDGE_W          = 15;
  localparam int START_EDGES     = 6;
  localparam int SHARED_EDGES    = 2;

  localparam logic CMD_PLACE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PCHK, S_NB, S_FIND, S_COMP, S_FDONE, S_MERGE, S_LINK, S_EMIT
  } state_t;

  // what a finished root search is used for
  typedef enum logic [1:0] {PH_Q, PH_N, PH_M} phase_t;

  typedef struct packed {
    logic              load;
    logic [EDGE_W-1:0] edge_count;
    logic [1:0]        status;
  } res_t;

  // neighbor offsets in visiting order
  function automatic logic signed [1:0] nb_dx(input logic [2:0] d);
    case (d)
      3'd1, 3'd2: nb_dx = 2'sd1;
      3'd4, 3'd5: nb_dx = -2'sd1;
      default:    nb_dx = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] nb_dy(input logic [2:0] d);
    case (d)
      3'd0, 3'd5: nb_dy = 2'sd1;
      3'd2, 3'd3: nb_dy = -2'sd1;
      default:    nb_dy = 2'sd0;
    endcase
  endfunction

endpackage

[sv/hcu_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hcu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/hcu_seq.sv]
// Command sequencer: placement, neighbor merge and root search with path
// compression over the cell memory. Depends on hcu_pkg.
module hcu_seq
  import hcu_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT,
  localparam int CW    = $clog2(CELLS),
  localparam int SW    = CW + 1,
  localparam int W     = 1 + CW + SW + EDGE_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          command,
  input  logic [5:0]    col,
  input  logic [5:0]    row,
  input  logic          res_free,
  output res_t          res,
  output logic          wr_en,
  output logic [CW-1:0] wr_addr,
  output logic [W-1:0]  wr_data,
  output logic          rd_en,
  output logic [CW-1:0] rd_addr,
  input  logic [W-1:0]  rd_data
);

  state_t state, state_next;
  phase_t phase, phase_next;
  logic [CW-1:0] clr_addr, clr_addr_next;
  logic [5:0] col_q, col_q_next, row_q, row_q_next;
  logic [CW-1:0] home, home_next, cur, cur_next, start, start_next;
  logic first, first_next;
  logic [CW-1:0] root, root_next, nroot, nroot_next;
  logic [SW-1:0] root_size, root_size_next, n_size, n_size_next;
  logic [EDGE_W-1:0] root_edges, root_edges_next, n_edges, n_edges_next;
  logic [2:0] d, d_next;
  logic [CW-1:0] link_cell, link_cell_next, link_parent, link_parent_next;
  logic [SW-1:0] link_size, link_size_next;
  logic [EDGE_W-1:0] link_edges, link_edges_next;
  logic [EDGE_W-1:0] res_edges, res_edges_next;
  logic [1:0] res_status, res_status_next;
  logic res_load;

  logic rd_occ;
  logic [CW-1:0] rd_parent;
  logic [SW-1:0] rd_size;
  logic [EDGE_W-1:0] rd_edges;
  logic inside_in;
  logic [CW-1:0] cell_in;
  logic signed [7:0] nx, ny;
  logic nb_ok;
  logic [CW-1:0] ncell;
  logic n_big;
  logic [SW-1:0] sum_size;
  logic [EDGE_W-1:0] sum_edges;

  // unpack the memory word
  assign rd_occ    = rd_data[W-1];
  assign rd_parent = rd_data[EDGE_W+SW +: CW];
  assign rd_size   = rd_data[EDGE_W +: SW];
  assign rd_edges  = rd_data[EDGE_W-1:0];

  // cell index of the incoming word
  assign inside_in = (32'(col) < GRID_WIDTH) && (32'(row) < GRID_HEIGHT);
  assign cell_in   = CW'(32'(row) * GRID_WIDTH + 32'(col));

  // neighbor of the current direction
  assign nx    = $signed({2'b00, col_q}) + 8'(nb_dx(d));
  assign ny    = $signed({2'b00, row_q}) + 8'(nb_dy(d));
  assign nb_ok = !nx[7] && !ny[7] && (32'(nx) < GRID_WIDTH) && (32'(ny) < GRID_HEIGHT);
  assign ncell = CW'(32'(ny[6:0]) * GRID_WIDTH + 32'(nx[6:0]));

  // merge arithmetic
  assign n_big     = n_size > root_size;
  assign sum_size  = n_size + root_size;
  assign sum_edges = n_edges + root_edges - EDGE_W'(SHARED_EDGES);

  assign in_ready       = (state == S_IDLE);
  assign res.load       = res_load;
  assign res.edge_count = res_edges;
  assign res.status     = res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
    phase       <= phase_next;
    col_q       <= col_q_next;
    row_q       <= row_q_next;
    home        <= home_next;
    cur         <= cur_next;
    start       <= start_next;
    first       <= first_next;
    root        <= root_next;
    root_size   <= root_size_next;
    root_edges  <= root_edges_next;
    nroot       <= nroot_next;
    n_size      <= n_size_next;
    n_edges     <= n_edges_next;
    d           <= d_next;
    link_cell   <= link_cell_next;
    link_parent <= link_parent_next;
    link_size   <= link_size_next;
    link_edges  <= link_edges_next;
    res_edges   <= res_edges_next;
    res_status  <= res_status_next;
  end

  // next state, memory access and result
  always_comb begin
    state_next       = state;
    phase_next       = phase;
    clr_addr_next    = clr_addr;
    col_q_next       = col_q;
    row_q_next       = row_q;
    home_next        = home;
    cur_next         = cur;
    start_next       = start;
    first_next       = first;
    root_next        = root;
    root_size_next   = root_size;
    root_edges_next  = root_edges;
    nroot_next       = nroot;
    n_size_next      = n_size;
    n_edges_next     = n_edges;
    d_next           = d;
    link_cell_next   = link_cell;
    link_parent_next = link_parent;
    link_size_next   = link_size;
    link_edges_next  = link_edges;
    res_edges_next   = res_edges;
    res_status_next  = res_status;
    res_load         = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = cur;
    wr_data          = '0;
    rd_en            = 1'b0;
    rd_addr          = cur;
    unique case (state)
      S_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == CW'(CELLS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          col_q_next = col;
          row_q_next = row;
          home_next  = cell_in;
          cur_next   = cell_in;
          start_next = cell_in;
          first_next = 1'b1;
          phase_next = PH_Q;
          if (!inside_in) begin
            if (command == CMD_QUERY) begin
              res_edges_next  = '0;
              res_status_next = ST_EMPTY;
              state_next      = S_EMIT;
            end
          end else begin
            rd_en   = 1'b1;
            rd_addr = cell_in;
            state_next = (command == CMD_QUERY) ? S_FIND : S_PCHK;
          end
        end
      end
      S_PCHK: begin
        if (rd_occ) begin
          res_edges_next  = '0;
          res_status_next = ST_DUP;
          state_next      = S_EMIT;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = home;
          wr_data    = {1'b1, home, SW'(1), EDGE_W'(START_EDGES)};
          d_next     = '0;
          state_next = S_NB;
        end
      end
      S_NB: begin
        if (d == 3'd6) begin
          state_next = S_IDLE;
        end else if (!nb_ok) begin
          d_next = d + 1'b1;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = ncell;
          cur_next   = ncell;
          start_next = ncell;
          first_next = 1'b1;
          phase_next = PH_N;
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        if (first && !rd_occ) begin
          if (phase == PH_Q) begin
            res_edges_next  = '0;
            res_status_next = ST_EMPTY;
            state_next      = S_EMIT;
          end else begin
            d_next     = d + 1'b1;
            state_next = S_NB;
          end
        end else if (rd_parent == cur) begin
          root_next       = cur;
          root_size_next  = rd_size;
          root_edges_next = rd_edges;
          first_next      = 1'b0;
          if (start == cur) begin
            state_next = S_FDONE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = start;
            cur_next   = start;
            state_next = S_COMP;
          end
        end else begin
          rd_en      = 1'b1;
          rd_addr    = rd_parent;
          cur_next   = rd_parent;
          first_next = 1'b0;
        end
      end
      S_COMP: begin
        // point this node straight at the root, then move up
        wr_en   = 1'b1;
        wr_addr = cur;
        wr_data = {rd_occ, root, rd_size, rd_edges};
        if (rd_parent == root) begin
          state_next = S_FDONE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = rd_parent;
          cur_next = rd_parent;
        end
      end
      S_FDONE: begin
        unique case (phase)
          PH_Q: begin
            res_edges_next  = root_edges;
            res_status_next = ST_OK;
            state_next      = S_EMIT;
          end
          PH_N: begin
            nroot_next   = root;
            n_size_next  = root_size;
            n_edges_next = root_edges;
            rd_en        = 1'b1;
            rd_addr      = home;
            cur_next     = home;
            start_next   = home;
            first_next   = 1'b0;
            phase_next   = PH_M;
            state_next   = S_FIND;
          end
          PH_M: begin
            state_next = S_MERGE;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_MERGE: begin
        wr_en = 1'b1;
        if (root == nroot) begin
          wr_addr    = nroot;
          wr_data    = {1'b1, nroot, n_size, n_edges - EDGE_W'(SHARED_EDGES)};
          d_next     = d + 1'b1;
          state_next = S_NB;
        end else begin
          wr_addr          = n_big ? nroot : root;
          wr_data          = {1'b1, wr_addr, sum_size, sum_edges};
          link_parent_next = n_big ? nroot : root;
          link_cell_next   = n_big ? root : nroot;
          link_size_next   = n_big ? root_size : n_size;
          link_edges_next  = n_big ? root_edges : n_edges;
          state_next       = S_LINK;
        end
      end
      S_LINK: begin
        wr_en      = 1'b1;
        wr_addr    = link_cell;
        wr_data    = {1'b1, link_parent, link_size, link_edges};
        d_next     = d + 1'b1;
        state_next = S_NB;
      end
      S_EMIT: begin
        if (res_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[sv/hex_cell_union_perimeter.sv]
// Hex cell union perimeter: places hexagonal cells and reports group edge counts.
// A query reads the cell and follows parent links to the root, compressing the path; a placement
// checks the cell, writes it and then visits each in-grid neighbor, merging occupied ones.
// One command is in flight at a time.
// Reset (synchronous) starts a clearing pass over all GRID_WIDTH*GRID_HEIGHT cells (4096 by
// default) with in_ready low; a finished word waits in the output register. Uses hcu_pkg.
module hex_cell_union_perimeter
  import hcu_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [5:0]        col,
  input  logic [5:0]        row,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [EDGE_W-1:0] edge_count,
  output logic [1:0]        status
);

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int CW    = $clog2(CELLS);
  localparam int W     = 1 + CW + (CW + 1) + EDGE_W;

  res_t          res;
  logic          res_free;
  logic          wr_en, rd_en;
  logic [CW-1:0] wr_addr, rd_addr;
  logic [W-1:0]  wr_data, rd_data;

  assign res_free = !out_valid || out_ready;

  hcu_seq #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command (command),
    .col     (col),
    .row     (row),
    .res_free(res_free),
    .res     (res),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hcu_ram #(
    .WIDTH(W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res.load) begin
      edge_count <= res.edge_count;
      status     <= res.status;
    end
  end

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready) else $error("input accepted during clearing pass");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    res.load |-> res_free) else $error("result overwrites a pending word");

  a_flag_zero_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> edge_count == '0)
    else $error("flagged word carries a nonzero count");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_DUP))
    else $error("unknown status code");

endmodule

[tb/sv/tb_hex_cell_union_perimeter.sv]
// Testbench for hex_cell_union_perimeter: drives place/query words, predicts
// group edge counts with a local union-find, checks results. Depends on hcu_pkg.
module tb_hex_cell_union_perimeter;
  import hcu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GW = GRID_WIDTH_DEF;
  localparam int GH = GRID_HEIGHT_DEF;
  localparam int CELLS = GW * GH;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic       cmd;
    logic [5:0] x;
    logic [5:0] y;
  } cmd_word_t;

  typedef struct {
    logic [EDGE_W-1:0] edges;
    logic [1:0]        st;
  } answer_t;

  logic clk, rst;
  logic in_valid, in_ready, command, out_valid, out_ready;
  logic [5:0] col, row;
  logic [EDGE_W-1:0] edge_count;
  logic [1:0] status;

  hex_cell_union_perimeter dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .col(col), .row(row), .out_valid(out_valid),
    .out_ready(out_ready), .edge_count(edge_count), .status(status)
  );

  // predictor state
  bit          placed [CELLS];
  int unsigned link   [CELLS];
  int unsigned gsize  [CELLS];
  int unsigned gedges [CELLS];

  cmd_word_t pending_words[$];
  answer_t   expected_answers[$];
  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  stim_done = 0;
  bit  in_taken = 0;
  bit  out_taken = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned find_root(int unsigned c);
    int unsigned r, nxt;
    r = c;
    while (link[r] != r) r = link[r];
    while (c != r) begin
      nxt = link[c];
      link[c] = r;
      c = nxt;
    end
    return r;
  endfunction

  // apply one accepted word to the predictor, queue any answer
  function automatic void predict_word(cmd_word_t w);
    int unsigned c, nc, nr, mr, big, sml;
    int nx, ny;
    answer_t a;
    c = w.y * GW + w.x;
    if (w.cmd == CMD_QUERY) begin
      if (!placed[c]) begin
        a.edges = '0; a.st = ST_EMPTY;
      end else begin
        a.edges = EDGE_W'(gedges[find_root(c)]); a.st = ST_OK;
      end
      expected_answers.insert(expected_answers.size(), a);
      return;
    end
    if (placed[c]) begin
      a.edges = '0; a.st = ST_DUP;
      expected_answers.insert(expected_answers.size(), a);
      return;
    end
    placed[c] = 1; link[c] = c; gsize[c] = 1; gedges[c] = START_EDGES;
    for (int d = 0; d < 6; d++) begin
      nx = int'(w.x) + int'(nb_dx(3'(d)));
      ny = int'(w.y) + int'(nb_dy(3'(d)));
      if (nx < 0 || ny < 0 || nx >= GW || ny >= GH) continue;
      nc = ny * GW + nx;
      if (!placed[nc]) continue;
      nr = find_root(nc);
      mr = find_root(c);
      if (nr == mr) begin
        gedges[nr] -= SHARED_EDGES;
        continue;
      end
      if (gsize[nr] > gsize[mr]) begin
        big = nr; sml = mr;
      end else begin
        big = mr; sml = nr;
      end
      gsize[big] += gsize[sml];
      link[sml] = big;
      gedges[big] = gedges[big] + gedges[sml] - SHARED_EDGES;
    end
  endfunction

  function automatic void add_word(logic cmd, int x, int y);
    cmd_word_t w;
    w.cmd = cmd; w.x = 6'(x); w.y = 6'(y);
    pending_words.insert(pending_words.size(), w);
  endfunction

  // fill the stimulus queue
  initial begin
    int cx, cy, r;
    // corners, empty queries, duplicates, a cell with all six neighbors placed around it
    add_word(CMD_QUERY, 0, 0);
    add_word(CMD_QUERY, 63, 63);
    add_word(CMD_PLACE, 0, 0);
    add_word(CMD_PLACE, 0, 0);
    add_word(CMD_QUERY, 0, 0);
    add_word(CMD_PLACE, 63, 63);
    add_word(CMD_PLACE, 63, 0);
    add_word(CMD_PLACE, 0, 63);
    add_word(CMD_QUERY, 63, 0);
    add_word(CMD_PLACE, 31, 31);
    add_word(CMD_PLACE, 31, 32);
    add_word(CMD_PLACE, 32, 31);
    add_word(CMD_PLACE, 32, 30);
    add_word(CMD_PLACE, 31, 30);
    add_word(CMD_PLACE, 30, 31);
    add_word(CMD_QUERY, 31, 31);
    add_word(CMD_PLACE, 30, 32);
    add_word(CMD_QUERY, 30, 32);
    add_word(CMD_PLACE, 30, 32);
    add_word(CMD_QUERY, 42, 21);
    // random: clustered blobs that grow and merge, plus scattered noise
    for (int i = 0; i < 1000; i++) begin
      if (i % 60 == 0) begin
        cx = $urandom_range(0, 63); cy = $urandom_range(0, 63);
      end
      r = $urandom_range(0, 9);
      if (r < 6)
        add_word(CMD_PLACE, (cx + $urandom_range(0, 8) - 4) & 63,
                 (cy + $urandom_range(0, 8) - 4) & 63);
      else if (r < 9)
        add_word(CMD_QUERY, (cx + $urandom_range(0, 8) - 4) & 63,
                 (cy + $urandom_range(0, 8) - 4) & 63);
      else
        add_word(1'($urandom_range(0, 1)), $urandom_range(0, 63), $urandom_range(0, 63));
    end
    stim_done = 1;
  end

  // reset
  initial begin
    rst = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
  end

  // driver: present words at the falling edge with random gaps
  int send_wait = 0;
  initial begin
    in_valid = 0; command = 0; col = 0; row = 0;
  end
  always @(negedge clk) begin
    bit hold;
    if (!rst) begin
      hold = in_valid && !in_taken;
      if (in_taken) begin
        in_taken = 0;
        send_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      end
      if (!hold) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 0;
        end else if (pending_words.size() > 0) begin
          in_valid <= 1;
          command  <= pending_words[0].cmd;
          col      <= pending_words[0].x;
          row      <= pending_words[0].y;
          pending_words.delete(0);
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // accepted words enter the predictor
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      cmd_word_t w;
      w.cmd = command; w.x = col; w.y = row;
      predict_word(w);
      in_taken = 1;
    end
  end

  // receiver stalls
  int recv_wait = 0;
  initial out_ready = 0;
  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else begin
      if (out_taken) begin
        out_taken = 0;
        recv_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 0;
      end else out_ready <= 1;
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      out_taken = 1;
      if (expected_answers.size() == 0) begin
        $error("unexpected result: edge_count %0d status %0d", edge_count, status);
        fail_count++;
      end else begin
        answer_t a;
        a = expected_answers[0];
        expected_answers.delete(0);
        if (edge_count !== a.edges) begin
          $error("edge_count expected %0d actual %0d", a.edges, edge_count);
          fail_count++;
        end
        if (status !== a.st) begin
          $error("status expected %0d actual %0d", a.st, status);
          fail_count++;
        end
      end
    end
  end

  // watchdog: count cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    @(posedge clk);
    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_answers.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_answers.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
